// ----- sv/awlc_pkg.sv -----
// ----------------------------------------------------------------------------
// awlc_pkg
// Widths, types, register codes and helpers shared by the adaptive weight
// limit controller and its iterative multiply/divide unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package awlc_pkg;

  // value width of weights, control, buffer, floor and ceiling
  localparam int WEIGHT_BITS = 48;

  localparam int W      = WEIGHT_BITS;
  localparam int LIM_W  = W + 1;            // control + buffer
  localparam int ZN_W   = 16;               // zeta numerator / denominator
  localparam int DIV_W  = 20;               // gamma / theta divisors
  localparam int DG_W   = 8;                // delta gear
  localparam int Z_W    = W + 17;           // zeta-scaled values, step
  localparam int ACC_W  = 2 * W + 33;       // discount product zb * raw
  localparam int CL_W   = Z_W + DG_W + 1;   // widest value before clamping
  localparam int CNT_W  = $clog2(Z_W + 1);

  // configuration port
  localparam int REG_COUNT = 7;
  localparam int DATA_W    = (W > 32) ? 64 : 32;
  localparam int ADDR_LSB  = $clog2(DATA_W / 8);
  localparam int ADDR_W    = $clog2(REG_COUNT * (DATA_W / 8));
  localparam int IDX_W     = ADDR_W - ADDR_LSB;

  typedef logic [W-1:0]      wval_t;
  typedef logic [LIM_W-1:0]  lval_t;
  typedef logic [Z_W-1:0]    zval_t;
  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [CL_W-1:0]   clval_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [IDX_W-1:0] {
    REG_WEIGHT_FLOOR,
    REG_ZETA_NUM,
    REG_ZETA_DEN,
    REG_GAMMA_DIV,
    REG_THETA_DIV,
    REG_DELTA_GEAR,
    REG_CEILING
  } reg_idx_t;

  // reset values of the registers
  localparam wval_t             RST_FLOOR   = wval_t'(64'd4000000);
  localparam logic [ZN_W-1:0]   RST_ZN      = ZN_W'(192);
  localparam logic [ZN_W-1:0]   RST_ZD      = ZN_W'(128);
  localparam logic [DIV_W-1:0]  RST_GD      = DIV_W'(37938);
  localparam logic [DIV_W-1:0]  RST_TD      = DIV_W'(37938);
  localparam logic [DG_W-1:0]   RST_DG      = DG_W'(10);
  localparam wval_t             RST_CEILING = wval_t'(64'hFFFF_FFFF_FFFF);
  localparam wval_t             RST_HALF    = RST_FLOOR >> 1;

  // command to the shared unit
  typedef struct packed {
    logic is_div;
    cnt_t n;       // multiplier bits, or quotient bits
  } awlc_cmd_t;

  // raise v to lo, then cap at hi (hi wins)
  function automatic wval_t clamp_val(input clval_t v, input wval_t lo, input wval_t hi);
    clval_t t;
    t = v;
    if (t < clval_t'(lo)) t = clval_t'(lo);
    if (t > clval_t'(hi)) t = clval_t'(hi);
    return t[W-1:0];
  endfunction

endpackage

// ----- sv/awlc_muldiv.sv -----
// ----------------------------------------------------------------------------
// awlc_muldiv
// Iterative shift-add multiplier and restoring divider, one bit per cycle,
// built around a single shared adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awlc_muldiv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  awlc_pkg::awlc_cmd_t cmd,
  input  awlc_pkg::acc_t      opa,     // multiplicand, or remainder start
  input  awlc_pkg::zval_t     opb,     // multiplier, or dividend bits MSB-aligned
  input  awlc_pkg::zval_t     opd,     // divisor
  output logic                done,
  output awlc_pkg::acc_t      result
);

  logic            busy_r;
  logic            is_div_r;
  awlc_pkg::cnt_t  cnt_r;
  logic            done_r;
  awlc_pkg::acc_t  acc_r;    // product, or remainder
  awlc_pkg::acc_t  mc_r;     // shifted multiplicand, or divisor
  awlc_pkg::zval_t sh_r;     // multiplier bits, or dividend/quotient bits

  logic [awlc_pkg::Z_W:0]   div_t;
  awlc_pkg::acc_t           add_a;
  awlc_pkg::acc_t           add_b;
  logic [awlc_pkg::ACC_W:0] sum;
  logic                     ge;

  // shared adder: add for multiply, subtract (with carry = no borrow) for divide
  always_comb begin
    div_t = {acc_r[awlc_pkg::Z_W-1:0], sh_r[awlc_pkg::Z_W-1]};
    add_a = is_div_r ? awlc_pkg::acc_t'(div_t) : acc_r;
    add_b = is_div_r ? ~mc_r : mc_r;
    sum   = {1'b0, add_a} + {1'b0, add_b} + {{awlc_pkg::ACC_W{1'b0}}, is_div_r};
    ge    = sum[awlc_pkg::ACC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.n;
      end else if (busy_r) begin
        cnt_r <= cnt_r - awlc_pkg::cnt_t'(1);
        if (cnt_r == awlc_pkg::cnt_t'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      is_div_r <= cmd.is_div;
      sh_r     <= opb;
      if (cmd.is_div) begin
        acc_r <= opa;
        mc_r  <= awlc_pkg::acc_t'(opd);
      end else begin
        acc_r <= '0;
        mc_r  <= opa;
      end
    end else if (busy_r) begin
      if (is_div_r) begin
        acc_r <= ge ? awlc_pkg::acc_t'(sum[awlc_pkg::Z_W-1:0])
                    : awlc_pkg::acc_t'(div_t[awlc_pkg::Z_W-1:0]);
        sh_r  <= {sh_r[awlc_pkg::Z_W-2:0], ge};
      end else begin
        if (sh_r[0]) acc_r <= sum[awlc_pkg::ACC_W-1:0];
        mc_r <= mc_r << 1;
        sh_r <= sh_r >> 1;
      end
    end
  end

  assign done   = done_r;
  assign result = is_div_r ? awlc_pkg::acc_t'(sh_r) : acc_r;

endmodule

// ----- sv/adaptive_weight_limit_controller_top.sv -----
// ----------------------------------------------------------------------------
// adaptive_weight_limit_controller_top
// Each item takes nine operations of the bit-serial multiply/divide unit,
//   one after another, or eleven when the buffer discount applies.
// Flow: one item at a time; in_stall is high while an item is in work.
//   A finished item waits in the output register.
// Reset: synchronous, active low; registers take their reset values and
//   control and buffer start at half the reset floor. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_weight_limit_controller_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  awlc_pkg::wval_t                   in_block_weight,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output awlc_pkg::wval_t                   out_new_control,
  output awlc_pkg::wval_t                   out_new_buffer,
  output awlc_pkg::wval_t                   out_new_limit,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [awlc_pkg::ADDR_W-1:0]       paddr,
  input  awlc_pkg::data_t                   pwdata,
  output awlc_pkg::data_t                   prdata,
  output logic                              pready
);

  typedef enum logic [4:0] {
    S_IDLE, S_BB, S_M1, S_D1, S_M2, S_D2, S_M3, S_D3, S_CMP,
    S_M4, S_D4, S_SEL, S_D5, S_M5, S_UPD, S_OUT
  } state_t;

  // configuration registers
  awlc_pkg::wval_t                floor_r;
  logic [awlc_pkg::ZN_W-1:0]      zn_r;
  logic [awlc_pkg::ZN_W-1:0]      zd_r;
  logic [awlc_pkg::DIV_W-1:0]     gd_r;
  logic [awlc_pkg::DIV_W-1:0]     td_r;
  logic [awlc_pkg::DG_W-1:0]      dg_r;
  awlc_pkg::wval_t                ceiling_r;

  logic [awlc_pkg::IDX_W-1:0]     cfg_idx;
  logic                           cfg_wr;

  // control state and outputs
  state_t          state_r, state_nxt;
  awlc_pkg::wval_t ctl_r, ctl_nxt;
  awlc_pkg::wval_t buf_r, buf_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            u_start_r, u_start_nxt;

  // work registers
  awlc_pkg::lval_t     x_r, x_nxt;
  awlc_pkg::lval_t     lim_r, lim_nxt;
  awlc_pkg::wval_t     bb_r, bb_nxt;
  awlc_pkg::zval_t     zx_r, zx_nxt;
  awlc_pkg::zval_t     zb_r, zb_nxt;
  awlc_pkg::zval_t     zl_r, zl_nxt;
  awlc_pkg::zval_t     raw_r, raw_nxt;
  awlc_pkg::zval_t     disc_r, disc_nxt;
  logic                grow_r, grow_nxt;
  awlc_pkg::zval_t     step_r, step_nxt;
  awlc_pkg::clval_t    dstep_r, dstep_nxt;
  awlc_pkg::awlc_cmd_t u_cmd_r, u_cmd_nxt;
  awlc_pkg::acc_t      u_opa_r, u_opa_nxt;
  awlc_pkg::zval_t     u_opb_r, u_opb_nxt;
  awlc_pkg::zval_t     u_opd_r, u_opd_nxt;
  awlc_pkg::wval_t     oc_r, oc_nxt;
  awlc_pkg::wval_t     ob_r, ob_nxt;
  awlc_pkg::wval_t     ol_r, ol_nxt;

  // shared unit
  logic            u_done;
  awlc_pkg::acc_t  u_res;

  // combinational helpers
  awlc_pkg::wval_t     half;
  awlc_pkg::zval_t     zd_eff, gd_eff, td_eff;
  awlc_pkg::lval_t     x_clamp;
  awlc_pkg::zval_t     e_z;
  awlc_pkg::zval_t     diff_sel;
  awlc_pkg::clval_t    ne_v, nb_v;

  awlc_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (u_start_r),
    .cmd    (u_cmd_r),
    .opa    (u_opa_r),
    .opb    (u_opb_r),
    .opd    (u_opd_r),
    .done   (u_done),
    .result (u_res)
  );

  // ---------------- configuration port ----------------
  assign cfg_idx = paddr[awlc_pkg::ADDR_W-1:awlc_pkg::ADDR_LSB];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r   <= awlc_pkg::RST_FLOOR;
      zn_r      <= awlc_pkg::RST_ZN;
      zd_r      <= awlc_pkg::RST_ZD;
      gd_r      <= awlc_pkg::RST_GD;
      td_r      <= awlc_pkg::RST_TD;
      dg_r      <= awlc_pkg::RST_DG;
      ceiling_r <= awlc_pkg::RST_CEILING;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        awlc_pkg::REG_WEIGHT_FLOOR: floor_r   <= pwdata[awlc_pkg::W-1:0];
        awlc_pkg::REG_ZETA_NUM:     zn_r      <= pwdata[awlc_pkg::ZN_W-1:0];
        awlc_pkg::REG_ZETA_DEN:     zd_r      <= pwdata[awlc_pkg::ZN_W-1:0];
        awlc_pkg::REG_GAMMA_DIV:    gd_r      <= pwdata[awlc_pkg::DIV_W-1:0];
        awlc_pkg::REG_THETA_DIV:    td_r      <= pwdata[awlc_pkg::DIV_W-1:0];
        awlc_pkg::REG_DELTA_GEAR:   dg_r      <= pwdata[awlc_pkg::DG_W-1:0];
        awlc_pkg::REG_CEILING:      ceiling_r <= pwdata[awlc_pkg::W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      awlc_pkg::REG_WEIGHT_FLOOR: prdata = awlc_pkg::data_t'(floor_r);
      awlc_pkg::REG_ZETA_NUM:     prdata = awlc_pkg::data_t'(zn_r);
      awlc_pkg::REG_ZETA_DEN:     prdata = awlc_pkg::data_t'(zd_r);
      awlc_pkg::REG_GAMMA_DIV:    prdata = awlc_pkg::data_t'(gd_r);
      awlc_pkg::REG_THETA_DIV:    prdata = awlc_pkg::data_t'(td_r);
      awlc_pkg::REG_DELTA_GEAR:   prdata = awlc_pkg::data_t'(dg_r);
      awlc_pkg::REG_CEILING:      prdata = awlc_pkg::data_t'(ceiling_r);
      default:                    prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    half     = floor_r >> 1;
    // a zero divisor acts as one
    zd_eff   = (zd_r == '0) ? awlc_pkg::zval_t'(1) : awlc_pkg::zval_t'(zd_r);
    gd_eff   = (gd_r == '0) ? awlc_pkg::zval_t'(1) : awlc_pkg::zval_t'(gd_r);
    td_eff   = (td_r == '0) ? awlc_pkg::zval_t'(1) : awlc_pkg::zval_t'(td_r);
    x_clamp  = (x_r > lim_r) ? lim_r : x_r;
    e_z      = awlc_pkg::zval_t'(ctl_r);
    diff_sel = (raw_r >= disc_r) ? (raw_r - disc_r) : (disc_r - raw_r);

    if (grow_r) begin
      ne_v = awlc_pkg::clval_t'(ctl_r) + awlc_pkg::clval_t'(step_r);
      nb_v = awlc_pkg::clval_t'(bb_r) + dstep_r;
    end else begin
      ne_v = (e_z >= step_r) ? awlc_pkg::clval_t'(e_z - step_r) : '0;
      nb_v = (awlc_pkg::clval_t'(bb_r) >= dstep_r)
             ? (awlc_pkg::clval_t'(bb_r) - dstep_r) : '0;
    end

    state_nxt     = state_r;
    ctl_nxt       = ctl_r;
    buf_nxt       = buf_r;
    out_valid_nxt = out_valid_r;
    u_start_nxt   = 1'b0;
    x_nxt         = x_r;
    lim_nxt       = lim_r;
    bb_nxt        = bb_r;
    zx_nxt        = zx_r;
    zb_nxt        = zb_r;
    zl_nxt        = zl_r;
    raw_nxt       = raw_r;
    disc_nxt      = disc_r;
    grow_nxt      = grow_r;
    step_nxt      = step_r;
    dstep_nxt     = dstep_r;
    u_cmd_nxt     = u_cmd_r;
    u_opa_nxt     = u_opa_r;
    u_opb_nxt     = u_opb_r;
    u_opd_nxt     = u_opd_r;
    oc_nxt        = oc_r;
    ob_nxt        = ob_r;
    ol_nxt        = ol_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt       = awlc_pkg::lval_t'(in_block_weight);
          lim_nxt     = awlc_pkg::lval_t'(ctl_r) + awlc_pkg::lval_t'(buf_r);
          // buffer / theta
          u_start_nxt = 1'b1;
          u_cmd_nxt   = '{is_div: 1'b1, n: awlc_pkg::cnt_t'(awlc_pkg::W)};
          u_opa_nxt   = '0;
          u_opb_nxt   = awlc_pkg::zval_t'(buf_r) << (awlc_pkg::Z_W - awlc_pkg::W);
          u_opd_nxt   = td_eff;
          state_nxt   = S_BB;
        end
      end
      S_BB: begin
        if (u_done) begin
          bb_nxt      = buf_r - u_res[awlc_pkg::W-1:0];
          u_start_nxt = 1'b1;
          u_cmd_nxt   = '{is_div: 1'b0, n: awlc_pkg::cnt_t'(awlc_pkg::ZN_W)};
          u_opa_nxt   = awlc_pkg::acc_t'(x_clamp);
          u_opb_nxt   = awlc_pkg::zval_t'(zn_r);
          state_nxt   = S_M1;
        end
      end
      S_M1, S_M2, S_M3: begin
        // product / zeta denominator
        if (u_done) begin
          u_start_nxt = 1'b1;
          u_cmd_nxt   = '{is_div: 1'b1, n: awlc_pkg::cnt_t'(awlc_pkg::Z_W)};
          u_opa_nxt   = '0;
          u_opb_nxt   = u_res[awlc_pkg::Z_W-1:0];
          u_opd_nxt   = zd_eff;
          priority case (state_r)
            S_M1:    state_nxt = S_D1;
            S_M2:    state_nxt = S_D2;
            default: state_nxt = S_D3;
          endcase
        end
      end
      S_D1: begin
        if (u_done) begin
          zx_nxt      = u_res[awlc_pkg::Z_W-1:0];
          u_start_nxt = 1'b1;
          u_cmd_nxt   = '{is_div: 1'b0, n: awlc_pkg::cnt_t'(awlc_pkg::ZN_W)};
          u_opa_nxt   = awlc_pkg::acc_t'(buf_r);
          u_opb_nxt   = awlc_pkg::zval_t'(zn_r);
          state_nxt   = S_M2;
        end
      end
      S_D2: begin
        if (u_done) begin
          zb_nxt      = u_res[awlc_pkg::Z_W-1:0];
          u_start_nxt = 1'b1;
          u_cmd_nxt   = '{is_div: 1'b0, n: awlc_pkg::cnt_t'(awlc_pkg::ZN_W)};
          u_opa_nxt   = awlc_pkg::acc_t'(lim_r);
          u_opb_nxt   = awlc_pkg::zval_t'(zn_r);
          state_nxt   = S_M3;
        end
      end
      S_D3: begin
        if (u_done) begin
          zl_nxt    = u_res[awlc_pkg::Z_W-1:0];
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (zx_r > e_z) begin
          raw_nxt = zx_r - e_z;
          if (zl_r > e_z) begin
            // discount numerator zb * raw
            u_start_nxt = 1'b1;
            u_cmd_nxt   = '{is_div: 1'b0, n: awlc_pkg::cnt_t'(awlc_pkg::Z_W)};
            u_opa_nxt   = awlc_pkg::acc_t'(zb_r);
            u_opb_nxt   = zx_r - e_z;
            state_nxt   = S_M4;
          end else begin
            disc_nxt  = '0;
            state_nxt = S_SEL;
          end
        end else begin
          grow_nxt    = 1'b0;
          u_start_nxt = 1'b1;
          u_cmd_nxt   = '{is_div: 1'b1, n: awlc_pkg::cnt_t'(awlc_pkg::Z_W)};
          u_opa_nxt   = '0;
          u_opb_nxt   = e_z - zx_r;
          u_opd_nxt   = gd_eff;
          state_nxt   = S_D5;
        end
      end
      S_M4: begin
        // discount never exceeds zb, so its quotient has one bit fewer
        if (u_done) begin
          u_start_nxt = 1'b1;
          u_cmd_nxt   = '{is_div: 1'b1, n: awlc_pkg::cnt_t'(awlc_pkg::Z_W - 1)};
          u_opa_nxt   = awlc_pkg::acc_t'(u_res[awlc_pkg::ACC_W-1:awlc_pkg::Z_W-1]);
          u_opb_nxt   = {u_res[awlc_pkg::Z_W-2:0], 1'b0};
          u_opd_nxt   = zl_r - e_z;
          state_nxt   = S_D4;
        end
      end
      S_D4: begin
        if (u_done) begin
          disc_nxt  = u_res[awlc_pkg::Z_W-1:0];
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        grow_nxt    = (raw_r >= disc_r);
        u_start_nxt = 1'b1;
        u_cmd_nxt   = '{is_div: 1'b1, n: awlc_pkg::cnt_t'(awlc_pkg::Z_W)};
        u_opa_nxt   = '0;
        u_opb_nxt   = diff_sel;
        u_opd_nxt   = gd_eff;
        state_nxt   = S_D5;
      end
      S_D5: begin
        if (u_done) begin
          step_nxt    = u_res[awlc_pkg::Z_W-1:0];
          u_start_nxt = 1'b1;
          u_cmd_nxt   = '{is_div: 1'b0, n: awlc_pkg::cnt_t'(awlc_pkg::DG_W)};
          u_opa_nxt   = awlc_pkg::acc_t'(u_res[awlc_pkg::Z_W-1:0]);
          u_opb_nxt   = awlc_pkg::zval_t'(dg_r);
          state_nxt   = S_M5;
        end
      end
      S_M5: begin
        if (u_done) begin
          dstep_nxt = u_res[awlc_pkg::CL_W-1:0];
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        ctl_nxt   = awlc_pkg::clamp_val(ne_v, half, ceiling_r);
        buf_nxt   = awlc_pkg::clamp_val(nb_v, half, ceiling_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          oc_nxt        = ctl_r;
          ob_nxt        = buf_r;
          ol_nxt        = awlc_pkg::clamp_val(
                            awlc_pkg::clval_t'(ctl_r) + awlc_pkg::clval_t'(buf_r),
                            floor_r, ceiling_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctl_r       <= awlc_pkg::RST_HALF;
      buf_r       <= awlc_pkg::RST_HALF;
      out_valid_r <= 1'b0;
      u_start_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctl_r       <= ctl_nxt;
      buf_r       <= buf_nxt;
      out_valid_r <= out_valid_nxt;
      u_start_r   <= u_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    lim_r   <= lim_nxt;
    bb_r    <= bb_nxt;
    zx_r    <= zx_nxt;
    zb_r    <= zb_nxt;
    zl_r    <= zl_nxt;
    raw_r   <= raw_nxt;
    disc_r  <= disc_nxt;
    grow_r  <= grow_nxt;
    step_r  <= step_nxt;
    dstep_r <= dstep_nxt;
    u_cmd_r <= u_cmd_nxt;
    u_opa_r <= u_opa_nxt;
    u_opb_r <= u_opb_nxt;
    u_opd_r <= u_opd_nxt;
    oc_r    <= oc_nxt;
    ob_r    <= ob_nxt;
    ol_r    <= ol_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_new_control = oc_r;
  assign out_new_buffer  = ob_r;
  assign out_new_limit   = ol_r;

endmodule
